[hdl/point_cloud_quantile_outlier_filter_assert.svh]
// assertion macros for the quantile outlier filter
// used by the top level only
`ifndef POINT_CLOUD_QUANTILE_OUTLIER_FILTER_ASSERT_SVH
`define POINT_CLOUD_QUANTILE_OUTLIER_FILTER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define PQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hdl/pcqof_pkg.sv]
// package for the quantile outlier filter: payload types, sizes
// no dependencies
package pcqof_pkg;
    localparam int MaxPoints  = 64;
    localparam int CoordBits  = 16;
    localparam int IdxW       = $clog2(MaxPoints);
    localparam int CntW       = $clog2(MaxPoints + 1);
    localparam int SumW       = CoordBits + IdxW;
    localparam int DistW      = 2 * CoordBits + 2;
    localparam int QfW        = 16;
    localparam logic [QfW-1:0] QfReset = 16'd58982;

    typedef struct packed {
        logic signed [CoordBits-1:0] coord_x;
        logic signed [CoordBits-1:0] coord_y;
        logic signed [CoordBits-1:0] coord_z;
        logic                        set_end;
    } t_in_item;

    typedef struct packed {
        logic signed [CoordBits-1:0] kept_x;
        logic signed [CoordBits-1:0] kept_y;
        logic signed [CoordBits-1:0] kept_z;
        logic                        empty_set;
        logic                        overflowed;
        logic                        final_result;
    } t_out_item;

    // descriptor of a closed set, handed from the front to the back
    typedef struct packed {
        logic [CntW-1:0]        count;
        logic                   ovf;
        logic signed [SumW-1:0] sx;
        logic signed [SumW-1:0] sy;
        logic signed [SumW-1:0] sz;
    } t_set_desc;
endpackage

[hdl/pcqof_front.sv]
// front end: stores points, sums axes, closes a set on set_end
// depends on pcqof_pkg
module pcqof_front import pcqof_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_data,
    output logic                  o_desc_valid,
    input  logic                  i_desc_stall,
    output t_set_desc             o_desc,
    output logic                  o_wr_en,
    output logic [IdxW-1:0]       o_wr_addr,
    output logic [3*CoordBits-1:0] o_wr_data
);
    logic [CntW-1:0]        r_count;
    logic                   r_ovf;
    logic signed [SumW-1:0] r_sx, r_sy, r_sz;
    logic                   r_dvalid;
    t_set_desc              r_desc;
    logic                   w_acc, w_room;

    // no new points while a set waits or the back end still reads the point store
    assign o_stall   = r_dvalid || i_desc_stall;
    assign w_acc     = i_valid && !o_stall;
    assign w_room    = (r_count < CntW'(MaxPoints));
    assign o_wr_en   = w_acc && w_room;
    assign o_wr_addr = r_count[IdxW-1:0];
    assign o_wr_data = {i_data.coord_x, i_data.coord_y, i_data.coord_z};
    assign o_desc_valid = r_dvalid;
    assign o_desc       = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sz     <= '0;
            r_dvalid <= 1'b0;
        end else begin
            if (r_dvalid && !i_desc_stall) begin
                r_dvalid <= 1'b0;
            end
            if (w_acc) begin
                if (i_data.set_end) begin
                    r_dvalid     <= 1'b1;
                    r_desc.count <= w_room ? r_count + 1'b1 : r_count;
                    r_desc.ovf   <= r_ovf || !w_room;
                    r_desc.sx    <= w_room ? r_sx + SumW'(i_data.coord_x) : r_sx;
                    r_desc.sy    <= w_room ? r_sy + SumW'(i_data.coord_y) : r_sy;
                    r_desc.sz    <= w_room ? r_sz + SumW'(i_data.coord_z) : r_sz;
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    r_sx    <= '0;
                    r_sy    <= '0;
                    r_sz    <= '0;
                end else if (w_room) begin
                    r_count <= r_count + 1'b1;
                    r_sx    <= r_sx + SumW'(i_data.coord_x);
                    r_sy    <= r_sy + SumW'(i_data.coord_y);
                    r_sz    <= r_sz + SumW'(i_data.coord_z);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end
endmodule

[hdl/pcqof_div.sv]
// restoring divider for signed sum by unsigned count, truncating toward zero
// depends on pcqof_pkg
module pcqof_div import pcqof_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [SumW-1:0] i_num,
    input  logic [CntW-1:0]        i_den,
    output logic                   o_done,
    output logic signed [CoordBits-1:0] o_quot
);
    localparam int StepW = $clog2(SumW + 1);
    logic [SumW-1:0]  r_mag, r_q;
    logic [SumW:0]    r_rem;
    logic [StepW-1:0] r_step;
    logic             r_neg, r_busy, r_done;
    logic [CntW-1:0]  r_den;
    logic [SumW:0]    w_trial;
    logic [SumW-1:0]  w_qs;

    assign w_trial = {r_rem[SumW-1:0], r_mag[SumW-1]} - (SumW+1)'(r_den);
    assign w_qs    = r_neg ? (~r_q + 1'b1) : r_q;
    assign o_done  = r_done;
    assign o_quot  = w_qs[CoordBits-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg  <= i_num[SumW-1];
                r_mag  <= i_num[SumW-1] ? (~i_num + 1'b1) : i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_step <= StepW'(SumW);
            end else if (r_busy) begin
                // one quotient bit a cycle
                if (!w_trial[SumW]) begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[SumW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[SumW-1:0], r_mag[SumW-1]};
                    r_q   <= {r_q[SumW-2:0], 1'b0};
                end
                r_mag  <= {r_mag[SumW-2:0], 1'b0};
                r_step <= r_step - 1'b1;
                if (r_step == StepW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

[hdl/pcqof_back.sv]
// back end: mean, distances, rank select by counting, filtered emission
// depends on pcqof_pkg and pcqof_div
module pcqof_back import pcqof_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [QfW-1:0]          i_qf,
    input  logic                    i_desc_valid,
    output logic                    o_desc_stall,
    input  t_set_desc               i_desc,
    input  logic                    i_wr_en,
    input  logic [IdxW-1:0]         i_wr_addr,
    input  logic [3*CoordBits-1:0]  i_wr_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output t_out_item               o_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_DIVX, S_DIVY, S_DIVZ, S_DRD, S_DMUL, S_DSUM,
        S_OUTER, S_INNER, S_DECIDE, S_FRD, S_FCHK, S_LAST, S_DONE
    } t_state;

    t_state r_state;
    logic [3*CoordBits-1:0] r_pmem [MaxPoints];
    logic [DistW-1:0]       r_dmem [MaxPoints];
    logic [3*CoordBits-1:0] r_prd;
    logic [DistW-1:0]       r_drd;
    logic [IdxW-1:0]        w_dwa;
    logic                   w_dwe;
    logic [DistW-1:0]       w_dwd;
    logic [IdxW-1:0]        r_raddr;

    logic [CntW-1:0]        r_n, r_i, r_j, r_lt, r_le, r_rank, r_kept;
    logic                   r_ovf;
    logic signed [CoordBits-1:0] r_mx, r_my, r_mz;
    logic [2*CoordBits-1:0] r_px, r_py, r_pz;
    logic [DistW-1:0]       r_cand, r_thr;
    logic                   r_ovalid;
    t_out_item              r_odata;
    t_out_item              r_pend;
    logic                   r_div_start;
    logic signed [SumW-1:0] r_num;
    logic                   w_div_done;
    logic signed [CoordBits-1:0] w_quot;
    logic signed [CoordBits:0]   w_dx, w_dy, w_dz;
    logic [CntW+QfW-1:0]    w_rprod;
    logic [CntW-1:0]        w_rank;

    pcqof_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   (r_n),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_desc_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    assign w_dx = (CoordBits+1)'($signed(r_prd[3*CoordBits-1 -: CoordBits])) - (CoordBits+1)'(r_mx);
    assign w_dy = (CoordBits+1)'($signed(r_prd[2*CoordBits-1 -: CoordBits])) - (CoordBits+1)'(r_my);
    assign w_dz = (CoordBits+1)'($signed(r_prd[CoordBits-1:0])) - (CoordBits+1)'(r_mz);
    assign w_rprod = (CntW+QfW)'(r_n) * (CntW+QfW)'(i_qf);
    assign w_rank  = CntW'(w_rprod >> QfW);

    // distance lands in the store at the end of the sum cycle
    assign w_dwe = (r_state == S_DSUM);
    assign w_dwa = r_i[IdxW-1:0];
    assign w_dwd = DistW'(r_px) + DistW'(r_py) + DistW'(r_pz);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_pmem[i_wr_addr] <= i_wr_data;
        end
        r_prd <= r_pmem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_dwe) begin
            r_dmem[w_dwa] <= w_dwd;
        end
        r_drd <= r_dmem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_desc_valid) begin
                        r_n         <= i_desc.count;
                        r_ovf       <= i_desc.ovf;
                        r_num       <= i_desc.sx;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (w_div_done) begin
                        r_mx        <= w_quot;
                        r_num       <= i_desc.sy;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (w_div_done) begin
                        r_my        <= w_quot;
                        r_num       <= i_desc.sz;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVZ;
                    end
                end
                S_DIVZ: begin
                    if (w_div_done) begin
                        r_mz    <= w_quot;
                        r_i     <= '0;
                        r_raddr <= '0;
                        r_state <= S_DRD;
                    end
                end
                S_DRD: r_state <= S_DMUL;
                S_DMUL: begin
                    r_px    <= (2*CoordBits)'(w_dx * w_dx);
                    r_py    <= (2*CoordBits)'(w_dy * w_dy);
                    r_pz    <= (2*CoordBits)'(w_dz * w_dz);
                    r_state <= S_DSUM;
                end
                S_DSUM: begin
                    if (r_i == r_n - 1'b1) begin
                        r_rank  <= (w_rank > r_n - 1'b1) ? r_n - 1'b1 : w_rank;
                        r_i     <= '0;
                        r_raddr <= '0;
                        r_state <= S_OUTER;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_raddr <= IdxW'(r_i + 1'b1);
                        r_state <= S_DRD;
                    end
                end
                S_OUTER: begin
                    // candidate read lands now; capture it next cycle
                    r_j     <= '0;
                    r_lt    <= '0;
                    r_le    <= '0;
                    r_raddr <= '0;
                    r_state <= S_INNER;
                end
                S_INNER: begin
                    // r_drd here is entry r_j-1 except on the first cycle
                    if (r_j != 0) begin
                        if (r_drd < r_cand)  r_lt <= r_lt + 1'b1;
                        if (r_drd <= r_cand) r_le <= r_le + 1'b1;
                    end else begin
                        r_cand <= r_drd;
                    end
                    if (r_j == r_n) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_raddr <= IdxW'(r_j + 1'b1);
                    end
                end
                S_DECIDE: begin
                    if (r_lt <= r_rank && r_rank < r_le) begin
                        r_thr   <= r_cand;
                        r_i     <= '0;
                        r_kept  <= '0;
                        r_raddr <= '0;
                        r_state <= S_FRD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_raddr <= IdxW'(r_i + 1'b1);
                        r_state <= S_OUTER;
                    end
                end
                S_FRD: r_state <= S_FCHK;
                S_FCHK: begin
                    // a kept point waits in r_pend until the next kept one or the end
                    if (r_drd < r_thr) begin
                        if (r_kept == 0 || !r_ovalid || !i_stall) begin
                            if (r_kept != 0) begin
                                r_ovalid <= 1'b1;
                                r_odata  <= r_pend;
                            end
                            r_pend <= '{kept_x: r_prd[3*CoordBits-1 -: CoordBits],
                                        kept_y: r_prd[2*CoordBits-1 -: CoordBits],
                                        kept_z: r_prd[CoordBits-1:0],
                                        empty_set: 1'b0, overflowed: r_ovf,
                                        final_result: 1'b0};
                            r_kept  <= r_kept + 1'b1;
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // advance, or close the set with the held beat or an empty marker
                    if (r_i == r_n - 1'b1) begin
                        if (r_kept == 0) begin
                            r_pend <= '{kept_x: '0, kept_y: '0, kept_z: '0,
                                        empty_set: 1'b1, overflowed: r_ovf,
                                        final_result: 1'b1};
                        end else begin
                            r_pend.final_result <= 1'b1;
                        end
                        r_state <= S_LAST;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_raddr <= IdxW'(r_i + 1'b1);
                        r_state <= S_FRD;
                    end
                end
                S_LAST: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_pend;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[hdl/point_cloud_quantile_outlier_filter.sv]
// quantile outlier filter top level; uses pcqof_pkg, pcqof_front, pcqof_back, assert macros
// processing order after set end: hand-over, three divides for the mean, the distance pass,
// the rank search by counting, then the filter pass, which output stalls can lengthen
// throughput: one point a cycle while loading; input stalls from set end until the back idles
// reset: synchronous active low, clears control state and sets the quantile to 0.9
`include "point_cloud_quantile_outlier_filter_assert.svh"
module point_cloud_quantile_outlier_filter import pcqof_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [QfW-1:0]   i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_item         i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_item        o_data
);
    logic [QfW-1:0]          r_qf;
    logic                    w_dvalid, w_dstall, w_we;
    t_set_desc               w_desc;
    logic [IdxW-1:0]         w_wa;
    logic [3*CoordBits-1:0]  w_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qf <= QfReset;
        end else if (i_cfg_we) begin
            r_qf <= i_cfg_data;
        end
    end

    pcqof_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data       (i_data),
        .o_desc_valid (w_dvalid),
        .i_desc_stall (w_dstall),
        .o_desc       (w_desc),
        .o_wr_en      (w_we),
        .o_wr_addr    (w_wa),
        .o_wr_data    (w_wd)
    );

    pcqof_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qf         (r_qf),
        .i_desc_valid (w_dvalid),
        .o_desc_stall (w_dstall),
        .i_desc       (w_desc),
        .i_wr_en      (w_we),
        .i_wr_addr    (w_wa),
        .i_wr_data    (w_wd),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

    `PQ_ASSERT_IMPL(a_empty_final, i_clk, i_rst_n, o_valid && o_data.empty_set, o_data.final_result, "empty marker must close the set")
    `PQ_ASSERT_IMPL(a_empty_zero, i_clk, i_rst_n, o_valid && o_data.empty_set, o_data.kept_x == 0 && o_data.kept_y == 0 && o_data.kept_z == 0, "empty marker carries zero coordinates")
    `PQ_ASSERT_NEXT(a_set_hold, i_clk, i_rst_n, w_dvalid && w_dstall, w_dvalid, "set descriptor dropped while held")
endmodule

[tb/tb_point_cloud_quantile_outlier_filter.sv]
// testbench for the quantile outlier filter: predicts kept points per set and checks output beats
// depends on pcqof_pkg and the point_cloud_quantile_outlier_filter top level
`timescale 1ns / 1ps
module tb_point_cloud_quantile_outlier_filter;
    import pcqof_pkg::*;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [QfW-1:0]  i_cfg_data;
    logic            i_valid;
    logic            o_stall;
    t_in_item        i_data;
    logic            o_valid;
    logic            i_stall;
    t_out_item       o_data;

    point_cloud_quantile_outlier_filter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    // predictor state
    logic [QfW-1:0]              quantile;
    logic signed [CoordBits-1:0] pts [MaxPoints][3];
    longint                      acc [3];
    int                          n_stored;
    bit                          dropped;

    t_in_item  pending_points[$];
    t_out_item kept_expected[$];
    int        errors;
    bit        hold_off;
    bit        drv_pause;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // model one accepted beat, queueing predicted kept points on set end
    task automatic predict_filter(input t_in_item it);
        longint    mean [3];
        longint    dsq [MaxPoints];
        longint    d, thr;
        int        rank, lt, le, kept;
        t_out_item r;
        if (n_stored < MaxPoints) begin
            pts[n_stored][0] = it.coord_x;
            pts[n_stored][1] = it.coord_y;
            pts[n_stored][2] = it.coord_z;
            acc[0] += it.coord_x;
            acc[1] += it.coord_y;
            acc[2] += it.coord_z;
            n_stored++;
        end else begin
            dropped = 1'b1;
        end
        if (!it.set_end) return;
        for (int a = 0; a < 3; a++) mean[a] = acc[a] / n_stored;
        for (int i = 0; i < n_stored; i++) begin
            dsq[i] = 0;
            for (int a = 0; a < 3; a++) begin
                d = longint'(pts[i][a]) - mean[a];
                dsq[i] += d * d;
            end
        end
        rank = int'((longint'(n_stored) * quantile) >> 16);
        if (rank > n_stored - 1) rank = n_stored - 1;
        thr = 0;
        for (int i = 0; i < n_stored; i++) begin
            lt = 0;
            le = 0;
            for (int j = 0; j < n_stored; j++) begin
                if (dsq[j] < dsq[i]) lt++;
                if (dsq[j] <= dsq[i]) le++;
            end
            if (lt <= rank && rank < le) begin
                thr = dsq[i];
                break;
            end
        end
        kept = 0;
        for (int i = 0; i < n_stored; i++) begin
            if (dsq[i] < thr) begin
                r = '0;
                r.kept_x = pts[i][0];
                r.kept_y = pts[i][1];
                r.kept_z = pts[i][2];
                r.overflowed = dropped;
                kept_expected = {kept_expected, r};
                kept++;
            end
        end
        if (kept == 0) begin
            r = '0;
            r.empty_set = 1'b1;
            r.overflowed = dropped;
            r.final_result = 1'b1;
            kept_expected = {kept_expected, r};
        end else begin
            r = kept_expected.pop_back();
            r.final_result = 1'b1;
            kept_expected = {kept_expected, r};
        end
        n_stored = 0;
        dropped = 1'b0;
        acc[0] = 0;
        acc[1] = 0;
        acc[2] = 0;
    endtask

    // driver
    int drv_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            drv_gap <= 0;
        end else if (i_valid && !o_stall) begin
            predict_filter(i_data);
            void'(pending_points.pop_front());
            if (pending_points.size() > 0 && !drv_pause && gap_len() == 0) begin
                i_data <= pending_points[0];
            end else begin
                i_valid <= 1'b0;
                drv_gap <= gap_len();
            end
        end else if (!i_valid) begin
            if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
            end else if (pending_points.size() > 0 && !drv_pause) begin
                i_valid <= 1'b1;
                i_data  <= pending_points[0];
            end
        end
    end

    // monitor and receiver stall
    int rcv_gap;
    int hold_count;
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rcv_gap <= 0;
            hold_count <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (kept_expected.size() == 0) begin
                    $error("unexpected beat %p", o_data);
                    errors++;
                end else begin
                    exp_r = kept_expected.pop_front();
                    if (o_data.kept_x !== exp_r.kept_x) begin
                        $error("kept_x exp %0d got %0d", exp_r.kept_x, o_data.kept_x);
                        errors++;
                    end
                    if (o_data.kept_y !== exp_r.kept_y) begin
                        $error("kept_y exp %0d got %0d", exp_r.kept_y, o_data.kept_y);
                        errors++;
                    end
                    if (o_data.kept_z !== exp_r.kept_z) begin
                        $error("kept_z exp %0d got %0d", exp_r.kept_z, o_data.kept_z);
                        errors++;
                    end
                    if (o_data.empty_set !== exp_r.empty_set) begin
                        $error("empty_set exp %0b got %0b", exp_r.empty_set, o_data.empty_set);
                        errors++;
                    end
                    if (o_data.overflowed !== exp_r.overflowed) begin
                        $error("overflowed exp %0b got %0b", exp_r.overflowed,
                               o_data.overflowed);
                        errors++;
                    end
                    if (o_data.final_result !== exp_r.final_result) begin
                        $error("final_result exp %0b got %0b", exp_r.final_result,
                               o_data.final_result);
                        errors++;
                    end
                end
            end
            // long hold-off counted here so the front fills and stalls
            if (hold_off && hold_count == 0) begin
                hold_count <= 3000;
                i_stall <= 1'b1;
            end else if (hold_count > 1) begin
                hold_count <= hold_count - 1;
            end else if (hold_count == 1) begin
                hold_count <= 0;
                i_stall <= 1'b0;
            end else if (rcv_gap > 0) begin
                rcv_gap <= rcv_gap - 1;
                i_stall <= (rcv_gap > 1);
            end else if (($urandom_range(0, 3) == 0)) begin
                rcv_gap <= gap_len();
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [CoordBits-1:0] rand_coord(input int mode);
        case (mode)
            0:       return 16'($urandom_range(0, 65535));
            1:       return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
            default: return $signed(16'($urandom_range(0, 255))) - 16'sd128;
        endcase
    endfunction

    task automatic queue_set(input int n_pts, input int mode);
        t_in_item it;
        for (int i = 0; i < n_pts; i++) begin
            it.coord_x = rand_coord(mode);
            it.coord_y = rand_coord(mode);
            it.coord_z = rand_coord(mode);
            it.set_end = (i == n_pts - 1);
            pending_points = {pending_points, it};
        end
    endtask

    task automatic queue_pt(input logic [15:0] x, y, z, input logic e);
        t_in_item it;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        it.set_end = e;
        pending_points = {pending_points, it};
    endtask

    // wait for the block to drain before touching the register
    task automatic wait_idle();
        while (pending_points.size() > 0 || i_valid || kept_expected.size() > 0)
            @(posedge i_clk);
        repeat (6000) @(posedge i_clk);
    endtask

    task automatic write_quantile(input logic [QfW-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        quantile = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    int sent_target;
    int qsel;
    initial begin
        errors = 0;
        hold_off = 1'b0;
        drv_pause = 1'b0;
        quantile = QfReset;
        n_stored = 0;
        dropped = 1'b0;
        acc[0] = 0;
        acc[1] = 0;
        acc[2] = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single point, extremes, ties, all equal
        queue_pt(16'h7fff, 16'h8000, 16'h0000, 1'b1);
        queue_pt(16'h8000, 16'h8000, 16'h8000, 1'b0);
        queue_pt(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        queue_pt(16'hffff, 16'h0001, 16'h8000, 1'b1);
        queue_pt(16'h0100, 16'h0100, 16'h0100, 1'b0);
        queue_pt(16'h0100, 16'h0100, 16'h0100, 1'b0);
        queue_pt(16'h0100, 16'h0100, 16'h0100, 1'b1);
        queue_pt(16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_pt(16'h0010, 16'h0000, 16'h0000, 1'b0);
        queue_pt(16'hfff0, 16'h0000, 16'h0000, 1'b0);
        queue_pt(16'h0400, 16'h0400, 16'hfc00, 1'b1);
        wait_idle();

        // extremes of the register
        write_quantile(16'h0000);
        queue_set(5, 2);
        wait_idle();
        write_quantile(16'hffff);
        queue_set(6, 1);
        wait_idle();

        // capacity exceeded, set end dropped too, then terminated later
        write_quantile(QfReset);
        queue_set(66, 2);
        pending_points[$].set_end = 1'b0;
        queue_pt(16'h1234, 16'h5678, 16'h9abc, 1'b1);
        wait_idle();

        // long receiver hold-off while the sender keeps feeding
        hold_off = 1'b1;
        queue_set(64, 0);
        queue_set(10, 2);
        repeat (2) @(posedge i_clk);
        hold_off = 1'b0;
        wait_idle();

        // random phases with several register settings
        sent_target = 150;
        while (sent_target > 0) begin
            qsel = $urandom_range(0, 4);
            case (qsel)
                0: write_quantile(16'h0000);
                1: write_quantile(16'hffff);
                2: write_quantile(QfReset);
                default: write_quantile(16'($urandom_range(0, 65535)));
            endcase
            for (int s = 0; s < 6 && sent_target > 0; s++) begin
                int n_pts;
                n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
                                                     : $urandom_range(1, 8);
                queue_set(n_pts, $urandom_range(0, 2));
                sent_target -= n_pts;
            end
            drv_pause = 1'b0;
            wait_idle();
        end

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hdl
hdl/pcqof_pkg.sv
hdl/pcqof_front.sv
hdl/pcqof_div.sv
hdl/pcqof_back.sv
hdl/point_cloud_quantile_outlier_filter.sv
tb/tb_point_cloud_quantile_outlier_filter.sv
